[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by conv2d_forward_multichannel.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define CNV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// Implication checked in the next cycle.
`define CNV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

[src/cnv_pkg.sv]
// ----------------------------------------------------------------------------
// cnv_pkg
// Types, constants and codes of the convolution block.
// ----------------------------------------------------------------------------
package cnv_pkg;

	// Store dimensions.
	localparam int MAX_CHANNELS = 16;
	localparam int MAX_DIM      = 64;
	localparam int MAX_FILTERS  = 16;
	localparam int MAX_KERNEL   = 8;

	localparam int WEIGHT_DEPTH = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
	localparam int SAMPLE_DEPTH = MAX_CHANNELS * MAX_DIM * MAX_DIM;

	// Command codes.
	localparam logic [1:0] CMD_WEIGHT  = 2'd0;
	localparam logic [1:0] CMD_BIAS    = 2'd1;
	localparam logic [1:0] CMD_SAMPLE  = 2'd2;
	localparam logic [1:0] CMD_COMPUTE = 2'd3;

	// Status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_POS = 2'd1;
	localparam logic [1:0] ST_BAD_PAD = 2'd2;

	// Register indexes.
	localparam logic [2:0] REG_CHANNELS = 3'd0;
	localparam logic [2:0] REG_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_WIDTH    = 3'd2;
	localparam logic [2:0] REG_FILTERS  = 3'd3;
	localparam logic [2:0] REG_KERNEL   = 3'd4;
	localparam logic [2:0] REG_STEP     = 3'd5;
	localparam logic [2:0] REG_PAD      = 3'd6;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic start;
		logic step;
		logic load;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] err;
		logic       last_tap;
		logic       no_taps;
		logic       out_free;
	} dp_stat_t;

endpackage

[src/cnv_if.sv]
// ----------------------------------------------------------------------------
// cnv_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface cnv_in_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  cmd;
	logic        [3:0]  filter_index;
	logic        [3:0]  channel_index;
	logic        [5:0]  row_index;
	logic        [5:0]  col_index;
	logic signed [15:0] data_value;

	modport source(output valid, cmd, filter_index, channel_index, row_index, col_index,
		data_value, input ready);
	modport sink(input valid, cmd, filter_index, channel_index, row_index, col_index,
		data_value, output ready);
endinterface

interface cnv_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_value;
	logic        [1:0]  status;

	modport source(output valid, result_value, status, input ready);
	modport sink(input valid, result_value, status, output ready);
endinterface

[src/cnv_ram.sv]
// ----------------------------------------------------------------------------
// cnv_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module cnv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write or read one entry a cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

[src/cnv_ctrl.sv]
// ----------------------------------------------------------------------------
// cnv_ctrl
// Controller: sequences loads, the tap loop, the drain and the result.
// ----------------------------------------------------------------------------
module cnv_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               is_compute,
	input  cnv_pkg::dp_stat_t  stat,
	output logic               ready,
	output cnv_pkg::ctrl_cmd_t cmd
);
	import cnv_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_RUN   = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0] state_q, state_d;
	logic [1:0] drain_q;

	// Next state and commands.
	always_comb begin
		state_d     = state_q;
		ready       = 1'b0;
		cmd         = '0;
		cmd.capture = accept;
		case (state_q)
			S_IDLE: begin
				ready = 1'b1;
				if (accept && is_compute) state_d = S_CHECK;
			end
			S_CHECK: begin
				cmd.start = 1'b1;
				if (stat.err != ST_OK) state_d = S_FIN;
				else if (stat.no_taps) state_d = S_DRAIN;
				else state_d = S_RUN;
			end
			S_RUN: begin
				cmd.step = 1'b1;
				if (stat.last_tap) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (drain_q == 2'd2) state_d = S_FIN;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and drain counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			drain_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DRAIN) drain_q <= drain_q + 2'd1;
			else drain_q <= '0;
		end
	end
endmodule

[src/cnv_dp.sv]
// ----------------------------------------------------------------------------
// cnv_dp
// Datapath: registers, stores, tap counters, multiply-accumulate and output.
// ----------------------------------------------------------------------------
module cnv_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  cnv_pkg::ctrl_cmd_t cmd,
	output cnv_pkg::dp_stat_t  stat,
	input  logic        [1:0]  in_cmd,
	input  logic        [3:0]  filter_index,
	input  logic        [3:0]  channel_index,
	input  logic        [5:0]  row_index,
	input  logic        [5:0]  col_index,
	input  logic signed [15:0] data_value,
	input  logic               wr_en,
	input  logic        [2:0]  wr_index,
	input  logic        [6:0]  wr_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result_value,
	output logic        [1:0]  status
);
	import cnv_pkg::*;

	localparam int WAW = $clog2(WEIGHT_DEPTH);
	localparam int SAW = $clog2(SAMPLE_DEPTH);
	localparam int BAW = $clog2(MAX_FILTERS);

	// Configuration registers.
	logic [4:0] chans_q, filters_q;
	logic [6:0] height_q, width_q;
	logic [3:0] kernel_q, step_q;
	logic [2:0] pad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chans_q   <= 5'd1;
			height_q  <= 7'd64;
			width_q   <= 7'd64;
			filters_q <= 5'd1;
			kernel_q  <= 4'd3;
			step_q    <= 4'd1;
			pad_q     <= 3'd0;
		end else if (wr_en) begin
			case (wr_index)
				REG_CHANNELS: chans_q   <= wr_data[4:0];
				REG_HEIGHT:   height_q  <= wr_data;
				REG_WIDTH:    width_q   <= wr_data;
				REG_FILTERS:  filters_q <= wr_data[4:0];
				REG_KERNEL:   kernel_q  <= wr_data[3:0];
				REG_STEP:     step_q    <= wr_data[3:0];
				REG_PAD:      pad_q     <= wr_data[2:0];
				default: ;
			endcase
		end
	end

	// Effective values after saturation; a step of zero counts as one.
	logic [4:0] chans, nfilt;
	logic [6:0] h, w;
	logic [3:0] ks, st;
	assign chans = (chans_q > 5'd16) ? 5'd16 : chans_q;
	assign nfilt = (filters_q > 5'd16) ? 5'd16 : filters_q;
	assign h     = (height_q > 7'd64) ? 7'd64 : height_q;
	assign w     = (width_q > 7'd64) ? 7'd64 : width_q;
	assign ks    = (kernel_q > 4'd8) ? 4'd8 : kernel_q;
	assign st    = (step_q == 4'd0) ? 4'd1 : step_q;

	// Captured compute item: filter and scaled window origin.
	logic [3:0] f_q;
	logic [9:0] rs_q, cs_q;
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			f_q  <= filter_index;
			rs_q <= 10'(row_index * st);
			cs_q <= 10'(col_index * st);
		end
	end

	// Status checks.
	logic [10:0] hp, wp;
	logic        bad_pos;
	assign hp      = 11'(h) + 11'({pad_q, 1'b0});
	assign wp      = 11'(w) + 11'({pad_q, 1'b0});
	assign bad_pos = ({1'b0, f_q} >= nfilt) || (11'(rs_q) + 11'(ks) > hp)
		|| (11'(cs_q) + 11'(ks) > wp);
	assign stat.err = ({1'b0, pad_q} >= ks) ? ST_BAD_PAD : (bad_pos ? ST_BAD_POS : ST_OK);
	assign stat.no_taps = (chans == 5'd0);

	// Tap counters over channel, kernel row and kernel column.
	logic [3:0] ch_q;
	logic [2:0] kr_q, kc_q;
	logic       kc_end, kr_end;
	assign kc_end        = ({1'b0, kc_q} == ks - 4'd1);
	assign kr_end        = ({1'b0, kr_q} == ks - 4'd1);
	assign stat.last_tap = kc_end && kr_end && ({1'b0, ch_q} == chans - 5'd1);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			ch_q <= '0;
			kr_q <= '0;
			kc_q <= '0;
		end else if (cmd.step) begin
			if (kc_end) begin
				kc_q <= '0;
				if (kr_end) begin
					kr_q <= '0;
					ch_q <= ch_q + 4'd1;
				end else begin
					kr_q <= kr_q + 3'd1;
				end
			end else begin
				kc_q <= kc_q + 3'd1;
			end
		end
	end

	// Input position of the current tap; padding taps are skipped.
	logic [10:0] ir, ic;
	logic        tap_ok;
	assign ir     = 11'(rs_q) + 11'(kr_q) - 11'(pad_q);
	assign ic     = 11'(cs_q) + 11'(kc_q) - 11'(pad_q);
	assign tap_ok = cmd.step && !ir[10] && (ir[9:0] < 10'(h)) && !ic[10]
		&& (ic[9:0] < 10'(w));

	// Stores: loads write in idle, the tap loop reads.
	logic           w_we, b_we, s_we;
	logic [WAW-1:0] w_addr;
	logic [SAW-1:0] s_addr;
	logic [BAW-1:0] b_addr;
	logic [15:0]    w_rd, s_rd, b_rd;

	assign w_we   = cmd.capture && (in_cmd == CMD_WEIGHT) && (row_index < 6'd8)
		&& (col_index < 6'd8);
	assign b_we   = cmd.capture && (in_cmd == CMD_BIAS);
	assign s_we   = cmd.capture && (in_cmd == CMD_SAMPLE);
	assign w_addr = w_we ? {filter_index, channel_index, row_index[2:0], col_index[2:0]}
		: {f_q, ch_q, kr_q, kc_q};
	assign s_addr = s_we ? {channel_index, row_index, col_index}
		: {ch_q, ir[5:0], ic[5:0]};
	assign b_addr = b_we ? filter_index : f_q;

	cnv_ram #(.WIDTH(16), .DEPTH(WEIGHT_DEPTH)) u_wram (
		.clk(clk), .we(w_we), .addr(w_addr), .wdata(data_value), .rdata(w_rd));
	cnv_ram #(.WIDTH(16), .DEPTH(SAMPLE_DEPTH)) u_sram (
		.clk(clk), .we(s_we), .addr(s_addr), .wdata(data_value), .rdata(s_rd));
	cnv_ram #(.WIDTH(16), .DEPTH(MAX_FILTERS)) u_bram (
		.clk(clk), .we(b_we), .addr(b_addr), .wdata(data_value), .rdata(b_rd));

	// Multiply-accumulate pipeline.
	logic               tv_s1, bv_s1, pv_s2;
	logic signed [31:0] prod_s2;
	logic signed [47:0] acc_q, bias_term, prod_term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tv_s1 <= 1'b0;
			bv_s1 <= 1'b0;
			pv_s2 <= 1'b0;
		end else begin
			tv_s1 <= tap_ok;
			bv_s1 <= cmd.start;
			pv_s2 <= tv_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(w_rd) * $signed(s_rd);
	end

	assign bias_term = bv_s1 ? {{24{b_rd[15]}}, b_rd, 8'd0} : '0;
	assign prod_term = pv_s2 ? 48'(prod_s2) : '0;

	always_ff @(posedge clk) begin
		if (cmd.start) acc_q <= '0;
		else acc_q <= acc_q + bias_term + prod_term;
	end

	// Saturation to 32 bits.
	logic signed [31:0] sat;
	always_comb begin
		if (acc_q[47:31] == '0 || acc_q[47:31] == '1) sat = acc_q[31:0];
		else if (acc_q[47]) sat = 32'sh8000_0000;
		else sat = 32'sh7FFF_FFFF;
	end

	// Output register.
	assign stat.out_free = !out_valid || out_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status       <= stat.err;
			result_value <= (stat.err == ST_OK) ? sat : '0;
		end
	end
endmodule

[src/conv2d_forward_multichannel.sv]
// ----------------------------------------------------------------------------
// conv2d_forward_multichannel
// Multi-channel 2D convolution forward pass with bias, stride and padding.
// ----------------------------------------------------------------------------
// Load items (weight, bias, sample) are taken back to back while the block is
// idle and give no result. A compute item holds the input stalled until its
// result is loaded into the output register. The single multiply-accumulate
// unit steps through the taps: it reads one weight and one sample per cycle
// from single-port stores, and padding taps still take a step. A compute item
// with bad status skips the tap loop and the drain, and the block is ready for
// the next item when that result enters the output register. A finished
// compute waits, with the input stalled, while the output register still holds
// an earlier result that has not been taken. Loads are taken while a finished
// result waits in the output register.
`include "assert_macros.svh"

module conv2d_forward_multichannel (
	input  logic       clk,
	input  logic       arst_n,
	cnv_in_if.sink     item,
	cnv_out_if.source  result,
	input  logic       wr_en,
	input  logic [2:0] wr_index,
	input  logic [6:0] wr_data
);
	import cnv_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	logic      accept;

	// An input transaction completes on valid and ready.
	assign accept = item.valid && item.ready;

	cnv_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .accept(accept),
		.is_compute(item.cmd == CMD_COMPUTE), .stat(stat),
		.ready(item.ready), .cmd(cmd));

	cnv_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_cmd(item.cmd), .filter_index(item.filter_index),
		.channel_index(item.channel_index), .row_index(item.row_index),
		.col_index(item.col_index), .data_value(item.data_value),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.out_valid(result.valid), .out_ready(result.ready),
		.result_value(result.result_value), .status(result.status));

	// A compute transaction makes the block busy in the next cycle.
	`CNV_ASSERT_NXT(a_busy_after_compute, clk, arst_n, accept && item.cmd == CMD_COMPUTE, !item.ready)
	// A new result only appears while the block is busy with a compute.
	`CNV_ASSERT_IMP(a_result_from_busy, clk, arst_n, $rose(result.valid), $past(!item.ready))
	// A failed status always carries a zero value.
	`CNV_ASSERT_IMP(a_err_zero, clk, arst_n, result.valid && result.status != ST_OK, result.result_value == 0)
endmodule
